// ===== design/pdc_pkg.sv =====
// shared types and constants for the packet deframer with crc-32 check
`timescale 1ns / 1ps

package pdc_pkg;

    localparam int unsigned INDEX_W      = 17;
    localparam int unsigned HEADER_BYTES = 15;
    localparam int unsigned IDX_TOTAL    = 4;
    localparam int unsigned IDX_LENGTH   = 8;
    localparam int unsigned IDX_KIND     = 10;
    localparam int unsigned IDX_CRC      = 11;

    localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_SHORT_HEADER  = 2'd1,
        ST_SHORT_PAYLOAD = 2'd2,
        ST_BAD_CRC       = 2'd3
    } status_t;

endpackage

// ===== design/pdc_if.sv =====
// byte input and result output channel interfaces
`timescale 1ns / 1ps

interface pdc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last_byte;

    modport source (output valid, output rx_byte, output last_byte, input ready);
    modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface pdc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        frame_done;
    logic [1:0]  frame_status;
    logic [31:0] seq_number;
    logic [31:0] chunk_total;
    logic [15:0] payload_length;
    logic [7:0]  packet_kind;

    modport source (
        output valid, output payload_byte, output payload_valid, output frame_done,
        output frame_status, output seq_number, output chunk_total,
        output payload_length, output packet_kind, input ready
    );
    modport sink (
        input valid, input payload_byte, input payload_valid, input frame_done,
        input frame_status, input seq_number, input chunk_total,
        input payload_length, input packet_kind, output ready
    );
endinterface

// ===== design/pdc_crc_step.sv =====
// reflected crc-32 update over one byte, eight bit steps unrolled
`timescale 1ns / 1ps

module pdc_crc_step (
    input  logic [31:0] crc_in,
    input  logic [7:0]  data,
    output logic [31:0] crc_out
);
    import pdc_pkg::*;

    always_comb
    begin
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        crc_out = c;
    end

endmodule

// ===== design/packet_deframer_crc32_check_core.sv =====
// top level: datagram header parse, payload pass-through and crc-32 check
// an accepted byte's result is written into the output register at the next clock edge
// throughput: one byte per cycle while the sink keeps taking results, set by the unrolled eight-bit crc update
// a new byte is taken while the previous result waits if the sink takes it too
// reset: crc preset to all ones, byte count and header registers cleared
// the same clear happens after each byte marked last
`timescale 1ns / 1ps

module packet_deframer_crc32_check_core (
    input logic       clk,
    input logic       rst_n,
    pdc_in_if.sink    rx,
    pdc_out_if.source tx
);
    import pdc_pkg::*;

    logic [31:0]        crc_reg, crc_next;
    logic [INDEX_W-1:0] byte_index_reg, byte_index_next;
    logic [31:0]        seq_reg, seq_next;
    logic [31:0]        total_reg, total_next;
    logic [15:0]        length_reg, length_next;
    logic [7:0]         kind_reg, kind_next;
    logic [31:0]        rx_crc_reg, rx_crc_next;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_pvalid_reg;
    logic        out_done_reg;
    status_t     out_status_reg;
    logic [31:0] out_seq_reg;
    logic [31:0] out_total_reg;
    logic [15:0] out_length_reg;
    logic [7:0]  out_kind_reg;

    logic               take;
    logic               in_header;
    logic               in_payload;
    logic [INDEX_W-1:0] payload_end;
    logic [INDEX_W-1:0] frame_end;
    logic [INDEX_W-1:0] idx_inc;
    logic [7:0]         crc_data;
    logic [31:0]        crc_upd;
    status_t            status;

    assign rx.ready = !out_valid_reg || tx.ready;
    assign take     = rx.valid && rx.ready;

    assign in_header   = byte_index_reg < INDEX_W'(HEADER_BYTES);
    assign payload_end = INDEX_W'(HEADER_BYTES) + {1'b0, length_reg};
    assign in_payload  = !in_header && (byte_index_reg < payload_end);
    assign crc_data    = (in_header && byte_index_reg >= INDEX_W'(IDX_CRC)) ? 8'd0 : rx.rx_byte;
    assign idx_inc     = (byte_index_reg == INDEX_MAX) ? byte_index_reg
                                                       : byte_index_reg + INDEX_W'(1);

    pdc_crc_step u_crc (
        .crc_in  (crc_reg),
        .data    (crc_data),
        .crc_out (crc_upd)
    );

    always_comb
    begin
        seq_next    = seq_reg;
        total_next  = total_reg;
        length_next = length_reg;
        kind_next   = kind_reg;
        rx_crc_next = rx_crc_reg;
        crc_next    = crc_reg;
        if (in_header)
        begin
            if (byte_index_reg < INDEX_W'(IDX_TOTAL))
                seq_next = {seq_reg[23:0], rx.rx_byte};
            else if (byte_index_reg < INDEX_W'(IDX_LENGTH))
                total_next = {total_reg[23:0], rx.rx_byte};
            else if (byte_index_reg < INDEX_W'(IDX_KIND))
                length_next = {length_reg[7:0], rx.rx_byte};
            else if (byte_index_reg == INDEX_W'(IDX_KIND))
                kind_next = rx.rx_byte;
            else
                rx_crc_next = {rx_crc_reg[23:0], rx.rx_byte};
        end
        if (in_header || in_payload)
            crc_next = crc_upd;
        byte_index_next = idx_inc;
    end

    assign frame_end = INDEX_W'(HEADER_BYTES) + {1'b0, length_next};

    always_comb
    begin
        if (idx_inc < INDEX_W'(HEADER_BYTES))
            status = ST_SHORT_HEADER;
        else if (idx_inc < frame_end)
            status = ST_SHORT_PAYLOAD;
        else if ((crc_next ^ CRC_INIT) != rx_crc_next)
            status = ST_BAD_CRC;
        else
            status = ST_OK;
    end

    // datagram state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg        <= CRC_INIT;
            byte_index_reg <= '0;
            seq_reg        <= '0;
            total_reg      <= '0;
            length_reg     <= '0;
            kind_reg       <= '0;
            rx_crc_reg     <= '0;
        end
        else if (take)
        begin
            if (rx.last_byte)
            begin
                crc_reg        <= CRC_INIT;
                byte_index_reg <= '0;
                seq_reg        <= '0;
                total_reg      <= '0;
                length_reg     <= '0;
                kind_reg       <= '0;
                rx_crc_reg     <= '0;
            end
            else
            begin
                crc_reg        <= crc_next;
                byte_index_reg <= byte_index_next;
                seq_reg        <= seq_next;
                total_reg      <= total_next;
                length_reg     <= length_next;
                kind_reg       <= kind_next;
                rx_crc_reg     <= rx_crc_next;
            end
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= 1'b1;
        else if (tx.ready)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_byte_reg   <= in_payload ? rx.rx_byte : 8'd0;
            out_pvalid_reg <= in_payload;
            out_done_reg   <= rx.last_byte;
            out_status_reg <= rx.last_byte ? status : ST_OK;
            out_seq_reg    <= seq_next;
            out_total_reg  <= total_next;
            out_length_reg <= length_next;
            out_kind_reg   <= kind_next;
        end
    end

    assign tx.valid          = out_valid_reg;
    assign tx.payload_byte   = out_byte_reg;
    assign tx.payload_valid  = out_pvalid_reg;
    assign tx.frame_done     = out_done_reg;
    assign tx.frame_status   = out_status_reg;
    assign tx.seq_number     = out_seq_reg;
    assign tx.chunk_total    = out_total_reg;
    assign tx.payload_length = out_length_reg;
    assign tx.packet_kind    = out_kind_reg;

endmodule
